>>> src/jddm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_pkg
// Shared types and constants of the joystick differential drive mixer.
// ----------------------------------------------------------------------------
package jddm_pkg;

  // Stick axis calibration: rest position, dead zone and full-scale reading
  localparam int unsigned AXIS_CENTRE = 1830;
  localparam int unsigned DEAD_ZONE   = 60;
  localparam int unsigned AXIS_TOP    = 4080;
  localparam int unsigned POS_SPAN    = AXIS_TOP - AXIS_CENTRE;

  localparam int unsigned SPEED_W     = 9;
  localparam int unsigned LIMIT_W     = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic        [LIMIT_W-1:0] speed_limit_t;

endpackage

>>> src/jddm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_in_if
// Joystick sample channel: two axis readings and the push button.
// ----------------------------------------------------------------------------
interface jddm_in_if #(
  parameter int unsigned ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] forward_adc;
  logic [ADC_BITS-1:0] turn_adc;
  logic                button_down;

  modport source (output valid, output forward_adc, output turn_adc, output button_down,
                  input ready);
  modport sink   (input valid, input forward_adc, input turn_adc, input button_down,
                  output ready);
endinterface

>>> src/jddm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jddm_out_if
// Motor command channel: left and right speeds plus the button event.
// ----------------------------------------------------------------------------
interface jddm_out_if;
  logic             valid;
  logic             ready;
  jddm_pkg::speed_t left_speed;
  jddm_pkg::speed_t right_speed;
  logic             button_event;
  logic             button_state;

  modport source (output valid, output left_speed, output right_speed,
                  output button_event, output button_state, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input button_event, input button_state, output ready);
endinterface

>>> src/joystick_differential_drive_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer
// Flow: an accepted request passes the input, product, quotient and output registers in turn.
// Throughput: one request per cycle; each stage moves on when the next is free.
// Stages: input reg, product max*|offset|, reciprocal multiply, mix and clamp.
// Reset: pipeline empty, speed limit = 100, button taken as released.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  jddm_pkg::speed_limit_t  cfg_wdata_i,
  jddm_in_if.sink                 req_i,
  jddm_out_if.source              rsp_o
);
  import jddm_pkg::*;

  // Widths follow from the reading width
  localparam int unsigned OFF_W = ADC_BITS + 2;          // signed offset
  localparam int unsigned MAG_W = ADC_BITS + 1;          // offset magnitude
  localparam int unsigned P_W   = MAG_W + LIMIT_W;       // max * magnitude
  localparam int unsigned SHIFT = P_W + 12;              // reciprocal scale
  localparam int unsigned R_W   = SHIFT - 10;            // reciprocal width
  localparam int unsigned Q_W   = P_W - 10;              // quotient width
  localparam int unsigned M_W   = Q_W + 3;               // mix width, signed

  // Rounded-up reciprocals: error below 2^(P_W-SHIFT) keeps the quotient exact
  localparam logic [63:0] RECIP_POS_FULL =
    ((64'd1 << SHIFT) + 64'(POS_SPAN) - 64'd1) / 64'(POS_SPAN);
  localparam logic [63:0] RECIP_NEG_FULL =
    ((64'd1 << SHIFT) + 64'(AXIS_CENTRE) - 64'd1) / 64'(AXIS_CENTRE);
  localparam logic [R_W-1:0] RECIP_POS = RECIP_POS_FULL[R_W-1:0];
  localparam logic [R_W-1:0] RECIP_NEG = RECIP_NEG_FULL[R_W-1:0];

  localparam logic signed [OFF_W-1:0] CENTRE_OFF = OFF_W'(AXIS_CENTRE);
  localparam logic        [MAG_W-1:0] DEAD_MAG   = MAG_W'(DEAD_ZONE);

  // ---------------- configuration and button history -------------------
  speed_limit_t speed_limit_q;
  logic         button_last_q;

  logic s0_en, s1_en, s2_en, out_en;
  logic req_fire;
  logic ev_d;

  assign req_fire = req_i.valid && req_i.ready;
  assign ev_d     = req_i.button_down || (req_i.button_down != button_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= LIMIT_RESET;
      button_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        speed_limit_q <= cfg_wdata_i;
      end
      if (req_fire) begin
        button_last_q <= req_i.button_down;
      end
    end
  end

  // ---------------- stage enables ---------------------------------------
  logic s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;

  assign out_en      = !out_valid_q || rsp_o.ready;
  assign s2_en       = !s2_valid_q  || out_en;
  assign s1_en       = !s1_valid_q  || s2_en;
  assign s0_en       = !s0_valid_q  || s1_en;
  assign req_i.ready = s0_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_en)  s0_valid_q  <= req_i.valid;
      if (s1_en)  s1_valid_q  <= s0_valid_q;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (out_en) out_valid_q <= s2_valid_q;
    end
  end

  // ---------------- stage 0: input register -----------------------------
  logic [ADC_BITS-1:0] s0_fwd_q, s0_turn_q;
  logic                s0_event_q, s0_down_q;

  always_ff @(posedge clk_i) begin
    if (s0_en) begin
      s0_fwd_q   <= req_i.forward_adc;
      s0_turn_q  <= req_i.turn_adc;
      s0_event_q <= ev_d;
      s0_down_q  <= req_i.button_down;
    end
  end

  // ---------------- stage 1: offset, dead zone, max * magnitude ---------
  logic signed [OFF_W-1:0] off_x, off_y;
  logic        [OFF_W-1:0] abs_x, abs_y;
  logic        [MAG_W-1:0] mag_x, mag_y;
  logic        [P_W-1:0]   prod_x_d, prod_y_d;

  always_comb begin
    off_x = $signed({2'b00, s0_fwd_q})  - CENTRE_OFF;
    off_y = $signed({2'b00, s0_turn_q}) - CENTRE_OFF;
    abs_x = off_x[OFF_W-1] ? OFF_W'(-off_x) : OFF_W'(off_x);
    abs_y = off_y[OFF_W-1] ? OFF_W'(-off_y) : OFF_W'(off_y);
    mag_x = abs_x[MAG_W-1:0];
    mag_y = abs_y[MAG_W-1:0];
    if (mag_x < DEAD_MAG) mag_x = '0;
    if (mag_y < DEAD_MAG) mag_y = '0;
    prod_x_d = P_W'(speed_limit_q) * P_W'(mag_x);
    prod_y_d = P_W'(speed_limit_q) * P_W'(mag_y);
  end

  logic [P_W-1:0] s1_prod_x_q, s1_prod_y_q;
  logic           s1_neg_x_q, s1_neg_y_q, s1_event_q, s1_down_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_prod_x_q <= prod_x_d;
      s1_prod_y_q <= prod_y_d;
      s1_neg_x_q  <= off_x[OFF_W-1];
      s1_neg_y_q  <= off_y[OFF_W-1];
      s1_event_q  <= s0_event_q;
      s1_down_q   <= s0_down_q;
    end
  end

  // ---------------- stage 2: divide by span via reciprocal --------------
  logic [P_W+R_W-1:0] wide_x, wide_y;
  logic [Q_W-1:0]     quot_x_d, quot_y_d;

  always_comb begin
    wide_x   = (P_W+R_W)'(s1_prod_x_q) * (P_W+R_W)'(s1_neg_x_q ? RECIP_NEG : RECIP_POS);
    wide_y   = (P_W+R_W)'(s1_prod_y_q) * (P_W+R_W)'(s1_neg_y_q ? RECIP_NEG : RECIP_POS);
    quot_x_d = wide_x[SHIFT +: Q_W];
    quot_y_d = wide_y[SHIFT +: Q_W];
  end

  logic [Q_W-1:0] s2_quot_x_q, s2_quot_y_q;
  logic           s2_neg_x_q, s2_neg_y_q, s2_event_q, s2_down_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_quot_x_q <= quot_x_d;
      s2_quot_y_q <= quot_y_d;
      s2_neg_x_q  <= s1_neg_x_q;
      s2_neg_y_q  <= s1_neg_y_q;
      s2_event_q  <= s1_event_q;
      s2_down_q   <= s1_down_q;
    end
  end

  // ---------------- stage 3: arcade mix and clamp -----------------------
  logic signed [M_W-1:0] ax, y, f, g, lim;
  logic signed [M_W-1:0] left_m, right_m;

  always_comb begin
    ax  = $signed(M_W'(s2_quot_x_q));
    y   = s2_neg_y_q ? -$signed(M_W'(s2_quot_y_q)) : $signed(M_W'(s2_quot_y_q));
    lim = $signed(M_W'(speed_limit_q));
    f   = ax + y;
    g   = ax - y;
    // mirror only for a nonzero reverse speed
    if (s2_neg_x_q && (s2_quot_x_q != '0)) begin
      f = -f;
      g = -g;
    end
    left_m  = (f > lim) ? lim : ((f < -lim) ? -lim : f);
    right_m = (g > lim) ? lim : ((g < -lim) ? -lim : g);
  end

  speed_t out_left_q, out_right_q;
  logic   out_event_q, out_state_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_left_q  <= left_m[SPEED_W-1:0];
      out_right_q <= right_m[SPEED_W-1:0];
      out_event_q <= s2_event_q;
      out_state_q <= s2_down_q;   // pressed always flags an event
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.left_speed   = out_left_q;
  assign rsp_o.right_speed  = out_right_q;
  assign rsp_o.button_event = out_event_q;
  assign rsp_o.button_state = out_state_q;

  // ---------------- assertions ------------------------------------------
  a_left_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_left_q <= $signed({1'b0, speed_limit_q}))
                 && (out_left_q >= -$signed({1'b0, speed_limit_q})))
    else $error("left speed outside +-speed limit");

  a_right_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_right_q <= $signed({1'b0, speed_limit_q}))
                 && (out_right_q >= -$signed({1'b0, speed_limit_q})))
    else $error("right speed outside +-speed limit");

  a_state_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_state_q) |-> out_event_q)
    else $error("button state reported without event");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && s1_valid_q && s2_valid_q && out_valid_q && !rsp_o.ready)
      |-> !req_i.ready)
    else $error("request taken while pipeline is full and stalled");

  a_request_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> s0_valid_q)
    else $error("accepted request lost at input stage");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick differential drive mixer. Joystick
// samples go in through the request channel. Each sample accepted gets its
// expected motor command from a model of the stick scaling and arcade mixing,
// with its own button state and speed limit. Every command that comes out is
// checked field by field against the oldest prediction. The run covers
// directed corner samples, then random traffic under several idle patterns,
// a long output hold-off and a pause that drains the pipeline. The speed
// limit is rewritten between phases, while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import jddm_pkg::*;

  localparam int unsigned ADC_BITS = 12;

  typedef struct packed {
    speed_t left;
    speed_t right;
    logic   ev;
    logic   st;
  } motor_cmd_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we;
  speed_limit_t cfg_wdata;

  jddm_in_if #(.ADC_BITS(ADC_BITS)) req_if ();
  jddm_out_if                       rsp_if ();

  joystick_differential_drive_mixer #(.ADC_BITS(ADC_BITS)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // model state
  speed_limit_t model_speed_limit;
  logic         model_button_last;

  motor_cmd_t motor_cmd_q[$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles_left;
  logic       last_button_sent;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model
  function automatic int scaled_axis(input logic [ADC_BITS-1:0] raw);
    int off;
    int mag;
    int m;
    off = int'(raw) - int'(AXIS_CENTRE);
    mag = (off < 0) ? -off : off;
    m   = int'(model_speed_limit);
    if (mag < int'(DEAD_ZONE)) return 0;
    if (off > 0) return (m * off) / int'(POS_SPAN);
    return -((m * mag) / int'(AXIS_CENTRE));
  endfunction

  function automatic int clamped_speed(input int v);
    int m;
    m = int'(model_speed_limit);
    if (v > m) return m;
    if (v < -m) return -m;
    return v;
  endfunction

  function automatic motor_cmd_t predict_motor_cmd(input logic [ADC_BITS-1:0] fwd,
                                                   input logic [ADC_BITS-1:0] turn,
                                                   input logic btn);
    motor_cmd_t cmd;
    int x;
    int y;
    int ax;
    int f;
    int g;
    cmd.ev = 1'b0;
    if (btn || (btn != model_button_last)) begin
      model_button_last = btn;
      cmd.ev = 1'b1;
    end
    cmd.st = cmd.ev ? model_button_last : 1'b0;
    x  = scaled_axis(fwd);
    y  = scaled_axis(turn);
    ax = (x < 0) ? -x : x;
    f  = ax + y;
    g  = ax - y;
    if (x < 0) begin
      f = -f;
      g = -g;
    end
    cmd.left  = speed_t'(clamped_speed(f));
    cmd.right = speed_t'(clamped_speed(g));
    return cmd;
  endfunction

  // ---------------------------------------------------------------- output side
  always @(posedge clk_i) begin
    if (hold_cycles_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_cycles_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    motor_cmd_t got;
    motor_cmd_t exp_cmd;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.left  = rsp_if.left_speed;
      got.right = rsp_if.right_speed;
      got.ev    = rsp_if.button_event;
      got.st    = rsp_if.button_state;
      if (motor_cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: left %0d right %0d event %0b state %0b",
                   got.left, got.right, got.ev, got.st);
      end else begin
        exp_cmd = motor_cmd_q.pop_front();
        if (got !== exp_cmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("command mismatch: expected left %0d right %0d event %0b state %0b, got left %0d right %0d event %0b state %0b",
                     exp_cmd.left, exp_cmd.right, exp_cmd.ev, exp_cmd.st,
                     got.left, got.right, got.ev, got.st);
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side
  // entered at a clock edge; leaves at the edge where the request was accepted
  task automatic send_sample(input logic [ADC_BITS-1:0] fwd,
                             input logic [ADC_BITS-1:0] turn,
                             input logic btn);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.forward_adc <= fwd;
    req_if.turn_adc    <= turn;
    req_if.button_down <= btn;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    motor_cmd_q.push_back(predict_motor_cmd(fwd, turn, btn));
    last_button_sent = btn;
  endtask

  task automatic drain_pipeline();
    req_if.valid <= 1'b0;
    while (motor_cmd_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_speed_limit(input speed_limit_t value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    model_speed_limit = value;
    @(posedge clk_i);
  endtask

  // mostly values around the centre, dead zone and rails, some uniform
  function automatic logic [ADC_BITS-1:0] random_axis();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(4095);
      1: v = ($urandom_range(1) ? 1830 + $urandom_range(70, 50)
                                : 1830 - $urandom_range(70, 50));
      2: v = ($urandom_range(1) ? $urandom_range(100) : $urandom_range(4095, 3990));
      default: v = $urandom_range(2230, 1430);
    endcase
    return v[ADC_BITS-1:0];
  endfunction

  function automatic logic random_button();
    return ($urandom_range(99) < 30) ? ~last_button_sent : last_button_sent;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_limit_corners();
    send_sample(12'd1830, 12'd1830, 1'b0);
    send_sample(12'd1889, 12'd1771, 1'b0);
    send_sample(12'd1890, 12'd1770, 1'b1);
    send_sample(12'd4080, 12'd1830, 1'b1);
    send_sample(12'd4095, 12'd4095, 1'b0);
    send_sample(12'd0,    12'd0,    1'b0);
    send_sample(12'd0,    12'd4095, 1'b1);
    send_sample(12'd4095, 12'd0,    1'b1);
    send_sample(12'd1830, 12'd4095, 1'b0);
    send_sample(12'd1830, 12'd0,    1'b0);
    send_sample(12'd3000, 12'd2500, 1'b1);
    send_sample(12'd500,  12'd3500, 1'b0);
    send_sample(12'd0,    12'd1830, 1'b0);
  endtask

  task automatic test_full_limit_corners();
    write_speed_limit(8'd255);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_sample(12'd0,    12'd0,    1'b0);
    send_sample(12'd4095, 12'd0,    1'b0);
    send_sample(12'd0,    12'd4095, 1'b1);
    send_sample(12'd4080, 12'd4080, 1'b1);
  endtask

  task automatic test_zero_limit();
    write_speed_limit(8'd0);
    send_sample(12'd4095, 12'd4095, 1'b1);
    send_sample(12'd0,    12'd0,    1'b0);
    send_sample(12'd0,    12'd4095, 1'b0);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct, input speed_limit_t limit);
    write_speed_limit(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_sample(random_axis(), random_axis(), random_button());
  endtask

  // output held off long enough that the pipeline fills and stalls requests
  task automatic test_output_hold_off();
    write_speed_limit(speed_limit_t'($urandom_range(254, 1)));
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cycles_left = 300;
    repeat (60) send_sample(random_axis(), random_axis(), random_button());
  endtask

  task automatic test_sender_pause();
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    repeat (20) send_sample(random_axis(), random_axis(), random_button());
    drain_pipeline();
    repeat (20) send_sample(random_axis(), random_axis(), random_button());
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_if.valid       = 1'b0;
    req_if.forward_adc = '0;
    req_if.turn_adc    = '0;
    req_if.button_down = 1'b0;
    rsp_if.ready       = 1'b0;
    mismatches         = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_cycles_left   = 0;
    last_button_sent   = 1'b0;
    model_speed_limit  = LIMIT_RESET;
    model_button_last  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limit_corners();
    test_full_limit_corners();
    test_zero_limit();
    test_random_traffic(200, 0,  0,  8'd255);
    test_random_traffic(200, 65, 0,  speed_limit_t'($urandom_range(254, 1)));
    test_random_traffic(200, 0,  65, 8'd1);
    test_random_traffic(200, 13, 13, speed_limit_t'($urandom_range(255)));
    test_output_hold_off();
    test_sender_pause();

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

endmodule
